>>> rtl/triangle_measures_top_defines.svh
// Assertion macros for the triangle measures block.
// Used by the top level only; no other dependencies.
`ifndef TRIANGLE_MEASURES_TOP_DEFINES_SVH
`define TRIANGLE_MEASURES_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tm_pkg.sv
// Shared widths, stage counts and payload types for the triangle measures block.
// No dependencies; every other file but the defines header uses it.
package tm_pkg;

  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 8;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int SQ_W         = 2 * DIFF_W;
  localparam int LEN_W        = COORD_BITS + FRAC_BITS + 1;
  localparam int PER_W        = LEN_W + 2;
  localparam int AREA_W       = 2 * COORD_BITS + 1;
  localparam int RAD_W        = 2 * LEN_W;
  localparam int NUM_W        = AREA_W + 2 * FRAC_BITS;
  localparam int SQRT_STEPS   = LEN_W;
  localparam int DIV_STEPS    = NUM_W;
  localparam int FRONT_STAGES = 3;
  localparam int LAT          = FRONT_STAGES + SQRT_STEPS + DIV_STEPS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [LEN_W-1:0]             len_t;
  typedef logic [AREA_W-1:0]            area_t;
  typedef logic [PER_W-1:0]             per_t;

  typedef struct packed {
    len_t len;
    len_t alt;
  } lane_res_t;

  typedef struct packed {
    len_t       len_ab;
    len_t       len_ac;
    len_t       len_bc;
    per_t       perimeter;
    area_t      area_twice;
    len_t       alt_a;
    len_t       alt_b;
    len_t       alt_c;
    logic [2:0] zero_side_flags;
  } result_t;

endpackage

>>> rtl/tm_if.sv
// Valid/ready channel interfaces for triangle input and measure results.
// Depends on tm_pkg for field types.
interface tm_in_if;
  logic            valid;
  logic            ready;
  tm_pkg::coord_t  ax;
  tm_pkg::coord_t  ay;
  tm_pkg::coord_t  bx;
  tm_pkg::coord_t  by;
  tm_pkg::coord_t  cx;
  tm_pkg::coord_t  cy;

  modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
  modport sink   (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

interface tm_out_if;
  logic              valid;
  logic              ready;
  tm_pkg::len_t      len_ab;
  tm_pkg::len_t      len_ac;
  tm_pkg::len_t      len_bc;
  tm_pkg::per_t      perimeter;
  tm_pkg::area_t     area_twice;
  tm_pkg::len_t      alt_a;
  tm_pkg::len_t      alt_b;
  tm_pkg::len_t      alt_c;
  logic [2:0]        zero_side_flags;

  modport source (output valid, len_ab, len_ac, len_bc, perimeter, area_twice,
                  alt_a, alt_b, alt_c, zero_side_flags, input ready);
  modport sink   (input valid, len_ab, len_ac, len_bc, perimeter, area_twice,
                  alt_a, alt_b, alt_c, zero_side_flags, output ready);
endinterface

>>> rtl/tm_lane.sv
// One side lane: squared length, pipelined digit square root, pipelined
// restoring division of the doubled area by the length. Depends on tm_pkg.
module tm_lane (
  input  logic              clk,
  input  logic              adv,
  input  tm_pkg::coord_t    p0x,
  input  tm_pkg::coord_t    p0y,
  input  tm_pkg::coord_t    p1x,
  input  tm_pkg::coord_t    p1y,
  input  tm_pkg::area_t     area,
  output tm_pkg::lane_res_t res
);
  import tm_pkg::*;

  logic signed [DIFF_W-1:0] dx_s, dy_s;
  logic [DIFF_W-1:0]        dx_m, dy_m;
  logic [DIFF_W-1:0]        dx_r, dy_r;
  logic [SQ_W-1:0]          dxx_r, dyy_r, sum_r;

  logic [RAD_W-1:0]   rad_r  [SQRT_STEPS];
  logic [LEN_W-1:0]   root_r [SQRT_STEPS];
  logic [LEN_W+1:0]   rem_r  [SQRT_STEPS];

  logic [NUM_W-1:0]   num_r  [DIV_STEPS];
  logic [LEN_W-1:0]   den_r  [DIV_STEPS];
  logic [LEN_W:0]     drem_r [DIV_STEPS];
  logic [LEN_W-1:0]   q_r    [DIV_STEPS];

  assign dx_s = DIFF_W'(p0x) - DIFF_W'(p1x);
  assign dy_s = DIFF_W'(p0y) - DIFF_W'(p1y);
  assign dx_m = dx_s[DIFF_W-1] ? DIFF_W'(-dx_s) : DIFF_W'(dx_s);
  assign dy_m = dy_s[DIFF_W-1] ? DIFF_W'(-dy_s) : DIFF_W'(dy_s);

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r  <= dx_m;
      dy_r  <= dy_m;
      dxx_r <= dx_r * dx_r;
      dyy_r <= dy_r * dy_r;
      sum_r <= dxx_r + dyy_r;
    end
  end

  // square root: one result bit per stage, radicand pairs taken from the top
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    logic [RAD_W-1:0] rad_i;
    logic [LEN_W-1:0] root_i;
    logic [LEN_W+1:0] rem_i, rem_t, trial;

    if (g == 0) begin : g_first
      assign rad_i  = RAD_W'(sum_r) << (2 * FRAC_BITS);
      assign root_i = '0;
      assign rem_i  = '0;
    end else begin : g_next
      assign rad_i  = rad_r[g-1];
      assign root_i = root_r[g-1];
      assign rem_i  = rem_r[g-1];
    end

    assign rem_t = {rem_i[LEN_W-1:0], rad_i[RAD_W-1 -: 2]};
    assign trial = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[g] <= rad_i << 2;
        if (rem_t >= trial) begin
          rem_r[g]  <= rem_t - trial;
          root_r[g] <= {root_i[LEN_W-2:0], 1'b1};
        end else begin
          rem_r[g]  <= rem_t;
          root_r[g] <= {root_i[LEN_W-2:0], 1'b0};
        end
      end
    end
  end

  // restoring division; only the low quotient bits are kept
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic [NUM_W-1:0] num_i;
    logic [LEN_W-1:0] den_i, q_i;
    logic [LEN_W:0]   rem_i, rem_t;

    if (g == 0) begin : g_first
      assign num_i = NUM_W'(area) << (2 * FRAC_BITS);
      assign den_i = root_r[SQRT_STEPS-1];
      assign rem_i = '0;
      assign q_i   = '0;
    end else begin : g_next
      assign num_i = num_r[g-1];
      assign den_i = den_r[g-1];
      assign rem_i = drem_r[g-1];
      assign q_i   = q_r[g-1];
    end

    assign rem_t = {rem_i[LEN_W-1:0], num_i[NUM_W-1]};

    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[g] <= num_i << 1;
        den_r[g] <= den_i;
        if (rem_t >= {1'b0, den_i}) begin
          drem_r[g] <= rem_t - {1'b0, den_i};
          q_r[g]    <= {q_i[LEN_W-2:0], 1'b1};
        end else begin
          drem_r[g] <= rem_t;
          q_r[g]    <= {q_i[LEN_W-2:0], 1'b0};
        end
      end
    end
  end

  assign res.len = den_r[DIV_STEPS-1];
  assign res.alt = q_r[DIV_STEPS-1];

endmodule

>>> rtl/tm_area.sv
// Doubled area as the absolute cross product, with a delay line that feeds
// the lane dividers and the merge stage at matching times. Depends on tm_pkg.
module tm_area (
  input  logic           clk,
  input  logic           adv,
  input  tm_pkg::coord_t ax,
  input  tm_pkg::coord_t ay,
  input  tm_pkg::coord_t bx,
  input  tm_pkg::coord_t by,
  input  tm_pkg::coord_t cx,
  input  tm_pkg::coord_t cy,
  output tm_pkg::area_t  area_mid,
  output tm_pkg::area_t  area_end
);
  import tm_pkg::*;

  localparam int PROD_W = 2 * DIFF_W;
  localparam int CR_W   = PROD_W + 1;
  localparam int DLY_N  = SQRT_STEPS + DIV_STEPS;

  logic signed [DIFF_W-1:0] e1_r, e2_r, e3_r, e4_r;
  logic signed [PROD_W-1:0] m1_r, m2_r;
  logic signed [CR_W-1:0]   cross_s;
  logic [CR_W-1:0]          cross_m;
  area_t                    area_r;
  area_t                    dly_r [DLY_N];

  assign cross_s = CR_W'(m1_r) - CR_W'(m2_r);
  assign cross_m = cross_s[CR_W-1] ? CR_W'(-cross_s) : CR_W'(cross_s);

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r   <= DIFF_W'(bx) - DIFF_W'(ax);
      e2_r   <= DIFF_W'(cy) - DIFF_W'(ay);
      e3_r   <= DIFF_W'(by) - DIFF_W'(ay);
      e4_r   <= DIFF_W'(cx) - DIFF_W'(ax);
      m1_r   <= e1_r * e2_r;
      m2_r   <= e3_r * e4_r;
      area_r <= cross_m[AREA_W-1:0];
      dly_r[0] <= area_r;
      for (int k = 1; k < DLY_N; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  assign area_mid = dly_r[SQRT_STEPS-1];
  assign area_end = dly_r[DLY_N-1];

endmodule

>>> rtl/tm_merge.sv
// Merge stage: combines the three lane results and the area into one
// registered result, zeroing altitudes to zero-length sides. Depends on tm_pkg.
module tm_merge (
  input  logic              clk,
  input  logic              adv,
  input  tm_pkg::lane_res_t res_ab,
  input  tm_pkg::lane_res_t res_ac,
  input  tm_pkg::lane_res_t res_bc,
  input  tm_pkg::area_t     area,
  output tm_pkg::result_t   result
);
  import tm_pkg::*;

  result_t    res_r;
  logic [2:0] zero;

  assign zero = {res_bc.len == '0, res_ac.len == '0, res_ab.len == '0};

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.len_ab          <= res_ab.len;
      res_r.len_ac          <= res_ac.len;
      res_r.len_bc          <= res_bc.len;
      res_r.perimeter       <= PER_W'(res_ab.len) + PER_W'(res_ac.len) + PER_W'(res_bc.len);
      res_r.area_twice      <= area;
      res_r.alt_a           <= zero[2] ? '0 : res_bc.alt;
      res_r.alt_b           <= zero[1] ? '0 : res_ac.alt;
      res_r.alt_c           <= zero[0] ? '0 : res_ab.alt;
      res_r.zero_side_flags <= zero;
    end
  end

  assign result = res_r;

endmodule

>>> rtl/triangle_measures_top.sv
// From input transfer to result: 3 front stages, 25 square root stages,
// 49 divide stages, 1 merge stage. Throughput: one triangle per cycle unless
// stalled, set by the fully pipelined root and divide digit stages in each lane.
// The whole pipe holds while a result waits untaken.
// Reset (synchronous, active low) clears the stage valid bits only.
// Depends on tm_pkg, tm_if, tm_lane, tm_area, tm_merge and the defines header.
`include "triangle_measures_top_defines.svh"

module triangle_measures_top (
  input  logic     clk,
  input  logic     rst_n,
  tm_in_if.sink    in_ch,
  tm_out_if.source out_ch
);
  import tm_pkg::*;

  logic [LAT-1:0] valid_r;
  logic           adv;
  lane_res_t      res_ab, res_ac, res_bc;
  area_t          area_mid, area_end;
  result_t        result;

  assign adv         = !valid_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[LAT-2:0], in_ch.valid};
    end
  end

  tm_lane u_lane_ab (
    .clk(clk), .adv(adv),
    .p0x(in_ch.ax), .p0y(in_ch.ay), .p1x(in_ch.bx), .p1y(in_ch.by),
    .area(area_mid), .res(res_ab)
  );

  tm_lane u_lane_ac (
    .clk(clk), .adv(adv),
    .p0x(in_ch.ax), .p0y(in_ch.ay), .p1x(in_ch.cx), .p1y(in_ch.cy),
    .area(area_mid), .res(res_ac)
  );

  tm_lane u_lane_bc (
    .clk(clk), .adv(adv),
    .p0x(in_ch.bx), .p0y(in_ch.by), .p1x(in_ch.cx), .p1y(in_ch.cy),
    .area(area_mid), .res(res_bc)
  );

  tm_area u_area (
    .clk(clk), .adv(adv),
    .ax(in_ch.ax), .ay(in_ch.ay), .bx(in_ch.bx), .by(in_ch.by),
    .cx(in_ch.cx), .cy(in_ch.cy),
    .area_mid(area_mid), .area_end(area_end)
  );

  tm_merge u_merge (
    .clk(clk), .adv(adv),
    .res_ab(res_ab), .res_ac(res_ac), .res_bc(res_bc),
    .area(area_end), .result(result)
  );

  assign out_ch.valid           = valid_r[LAT-1];
  assign out_ch.len_ab          = result.len_ab;
  assign out_ch.len_ac          = result.len_ac;
  assign out_ch.len_bc          = result.len_bc;
  assign out_ch.perimeter       = result.perimeter;
  assign out_ch.area_twice      = result.area_twice;
  assign out_ch.alt_a           = result.alt_a;
  assign out_ch.alt_b           = result.alt_b;
  assign out_ch.alt_c           = result.alt_c;
  assign out_ch.zero_side_flags = result.zero_side_flags;

  `TM_ASSERT_NXT(a_accept_enters, clk, rst_n, in_ch.valid && in_ch.ready, valid_r[0], "accepted triangle not in pipe")
  `TM_ASSERT_IMP(a_zero_ab_alt, clk, rst_n, out_ch.valid && out_ch.zero_side_flags[0], (out_ch.alt_c == '0) && (out_ch.len_ab == '0), "zero side AB with nonzero altitude or length")
  `TM_ASSERT_IMP(a_flat_alt, clk, rst_n, out_ch.valid && (out_ch.area_twice == '0), (out_ch.alt_a == '0) && (out_ch.alt_b == '0) && (out_ch.alt_c == '0), "flat triangle with nonzero altitude")

endmodule
